// ===== rtl/core/cscan_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-scan scheduler package
// Sizes, stream layouts and result status codes used by the scheduler,
// which also sizes its pending-request store from them.
// ----------------------------------------------------------------------------
package cscan_pkg;

  // Store and field sizes.
  localparam int PENDING_DEPTH = 16;
  localparam int TRACK_BITS    = 16;
  localparam int ID_BITS       = 8;
  localparam int SLOT_BITS     = $clog2(PENDING_DEPTH);
  localparam int CNT_BITS      = SLOT_BITS + 1;
  localparam int ENTRY_BITS    = TRACK_BITS + ID_BITS;

  // Stream payload widths, padded to whole bytes.
  localparam int DATA_BITS   = ((ID_BITS + TRACK_BITS + 7) / 8) * 8;
  localparam int STATUS_BITS = 3;

  // Operation codes carried in the input tuser.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_QUEUED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_HANDED  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_IDLE    = 3'd4;

endpackage

// ===== rtl/core/cscan_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cscan_track_request_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-scan track request scheduler
// Grants one shared resource by track. Requests are granted at once when
// the resource is idle, else stored as pending or refused if the store is
// full; a release hands the resource to the pending request with the
// smallest track at or above the current one, else the smallest overall.
//
// Sequence: a request goes from the input transfer through S_EMIT to the
// output register; a release first scans the pending store one entry per
// cycle through its single read port, then passes S_PICK and S_EMIT.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register, while that result still waits for its transfer.
// Reset: asynchronous, active low; the resource is idle at track 0 and no
// request is pending. Stored tracks and owners are not cleared.
// ----------------------------------------------------------------------------
module cscan_track_request_scheduler
  import cscan_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_BITS-1:0]   s_axis_tdata,  // requester, track
  input  logic                   s_axis_tuser,  // operation
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DATA_BITS-1:0]   m_axis_tdata,  // grant_id, grant_track
  output logic [STATUS_BITS-1:0] m_axis_tuser   // status
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]               state_q, state_d;
  logic                     busy_q, busy_d;
  logic [TRACK_BITS-1:0]    cur_q, cur_d;
  logic [PENDING_DEPTH-1:0] valid_q, valid_d;

  // Scan pipeline and best candidates.
  logic [CNT_BITS-1:0]   scan_cnt_q, scan_cnt_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [SLOT_BITS-1:0]  chk_idx_q, chk_idx_d;
  logic                  up_found_q, up_found_d;
  logic [SLOT_BITS-1:0]  up_idx_q, up_idx_d;
  logic [TRACK_BITS-1:0] up_trk_q, up_trk_d;
  logic [ID_BITS-1:0]    up_own_q, up_own_d;
  logic                  all_found_q, all_found_d;
  logic [SLOT_BITS-1:0]  all_idx_q, all_idx_d;
  logic [TRACK_BITS-1:0] all_trk_q, all_trk_d;
  logic [ID_BITS-1:0]    all_own_q, all_own_d;

  // Pending result and output register.
  logic [STATUS_BITS-1:0] res_st_q, res_st_d;
  logic [ID_BITS-1:0]     res_id_q, res_id_d;
  logic [TRACK_BITS-1:0]  res_trk_q, res_trk_d;
  logic                   m_valid_q, m_valid_d;
  logic [STATUS_BITS-1:0] m_st_q, m_st_d;
  logic [ID_BITS-1:0]     m_id_q, m_id_d;
  logic [TRACK_BITS-1:0]  m_trk_q, m_trk_d;

  // Store ports.
  logic                  ram_we, ram_re;
  logic [SLOT_BITS-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
  logic [TRACK_BITS-1:0] rd_trk;
  logic [ID_BITS-1:0]    rd_own;

  // Input fields.
  logic                  in_xfer;
  logic                  in_op;
  logic [ID_BITS-1:0]    in_id;
  logic [TRACK_BITS-1:0] in_trk;

  // Lowest free slot.
  logic                 free_any;
  logic [SLOT_BITS-1:0] free_idx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser;
  assign in_id         = s_axis_tdata[ID_BITS-1:0];
  assign in_trk        = s_axis_tdata[ID_BITS +: TRACK_BITS];

  assign rd_trk = ram_rdata[TRACK_BITS-1:0];
  assign rd_own = ram_rdata[TRACK_BITS +: ID_BITS];

  // Priority encoder for the lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  // Pending store: track in the low bits, owner above it.
  cscan_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (PENDING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and scheduling state.
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    cur_d       = cur_q;
    valid_d     = valid_q;
    scan_cnt_d  = scan_cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = scan_cnt_q[SLOT_BITS-1:0];
    up_found_d  = up_found_q;
    up_idx_d    = up_idx_q;
    up_trk_d    = up_trk_q;
    up_own_d    = up_own_q;
    all_found_d = all_found_q;
    all_idx_d   = all_idx_q;
    all_trk_d   = all_trk_q;
    all_own_d   = all_own_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_trk_d   = res_trk_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_st_d      = m_st_q;
    m_id_d      = m_id_q;
    m_trk_d     = m_trk_q;
    ram_we      = 1'b0;
    ram_waddr   = free_idx;
    ram_wdata   = {in_id, in_trk};
    ram_re      = 1'b0;
    ram_raddr   = scan_cnt_q[SLOT_BITS-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_id_d  = '0;
          res_trk_d = '0;
          state_d   = S_EMIT;
          if (in_op == OP_REQUEST) begin
            priority if (!busy_q) begin
              busy_d    = 1'b1;
              cur_d     = in_trk;
              res_st_d  = ST_GRANTED;
              res_id_d  = in_id;
              res_trk_d = in_trk;
            end else if (free_any) begin
              valid_d[free_idx] = 1'b1;
              ram_we            = 1'b1;
              res_st_d          = ST_QUEUED;
            end else begin
              res_st_d = ST_FULL;
            end
          end else begin
            scan_cnt_d  = '0;
            up_found_d  = 1'b0;
            all_found_d = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; judge the entry returned by the registered read.
        if (scan_cnt_q < CNT_BITS'(PENDING_DEPTH)) begin
          ram_re     = 1'b1;
          chk_vld_d  = 1'b1;
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (chk_vld_q && valid_q[chk_idx_q]) begin
          if (!all_found_q || rd_trk < all_trk_q) begin
            all_found_d = 1'b1;
            all_idx_d   = chk_idx_q;
            all_trk_d   = rd_trk;
            all_own_d   = rd_own;
          end
          if (rd_trk >= cur_q && (!up_found_q || rd_trk < up_trk_q)) begin
            up_found_d = 1'b1;
            up_idx_d   = chk_idx_q;
            up_trk_d   = rd_trk;
            up_own_d   = rd_own;
          end
        end
        if (chk_vld_q && chk_idx_q == SLOT_BITS'(PENDING_DEPTH - 1)) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        // Prefer the upward candidate, then wrap around.
        state_d = S_EMIT;
        priority if (up_found_q) begin
          valid_d[up_idx_q] = 1'b0;
          busy_d            = 1'b1;
          cur_d             = up_trk_q;
          res_st_d          = ST_HANDED;
          res_id_d          = up_own_q;
          res_trk_d         = up_trk_q;
        end else if (all_found_q) begin
          valid_d[all_idx_q] = 1'b0;
          busy_d             = 1'b1;
          cur_d              = all_trk_q;
          res_st_d           = ST_HANDED;
          res_id_d           = all_own_q;
          res_trk_d          = all_trk_q;
        end else begin
          busy_d    = 1'b0;
          res_st_d  = ST_IDLE;
          res_id_d  = '0;
          res_trk_d = '0;
        end
      end

      S_EMIT: begin
        // Move the result into the output register once it is free.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_st_d    = res_st_q;
          m_id_d    = res_id_q;
          m_trk_d   = res_trk_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      cur_q       <= '0;
      valid_q     <= '0;
      scan_cnt_q  <= '0;
      chk_vld_q   <= 1'b0;
      up_found_q  <= 1'b0;
      all_found_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      cur_q       <= cur_d;
      valid_q     <= valid_d;
      scan_cnt_q  <= scan_cnt_d;
      chk_vld_q   <= chk_vld_d;
      up_found_q  <= up_found_d;
      all_found_q <= all_found_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    up_idx_q  <= up_idx_d;
    up_trk_q  <= up_trk_d;
    up_own_q  <= up_own_d;
    all_idx_q <= all_idx_d;
    all_trk_q <= all_trk_d;
    all_own_q <= all_own_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_trk_q <= res_trk_d;
    m_st_q    <= m_st_d;
    m_id_q    <= m_id_d;
    m_trk_q   <= m_trk_d;
  end

  // Result stream.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tdata  = DATA_BITS'({m_trk_q, m_id_q});

endmodule
